FILE: design/saic_pkg.sv
// Shared constants, types and command codes of the instruction-cache tag block.
package saic_pkg;

	localparam int LINE_COUNT = 1024;
	localparam int LINE_AW    = 10;
	localparam int MAX_WAYS   = 8;
	localparam int WAY_W      = 3;
	localparam int FILL_W     = 4;
	localparam int ADDR_BITS  = 32;
	localparam int TAG_W      = 32;
	localparam int PAGE_W     = 20;
	localparam int CLR_W      = 11;
	localparam int LINE_DW    = 1 + TAG_W + PAGE_W;

	localparam logic [1:0] CFG_BLOCK_LOG2 = 2'd0;
	localparam logic [1:0] CFG_PAGE_LOG2  = 2'd1;
	localparam logic [1:0] CFG_SET_LOG2   = 2'd2;
	localparam logic [1:0] CFG_WAY_COUNT  = 2'd3;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLR,
		DP_START,
		DP_ADDR,
		DP_PRB_RD,
		DP_PRB_CK,
		DP_FILL_RD,
		DP_FILL_CK,
		DP_ORD_RD,
		DP_ORD_CK,
		DP_HIT,
		DP_LINE_WR,
		DP_CALC,
		DP_ORD_WR,
		DP_FILL_WR,
		DP_INV_RD,
		DP_INV_WR,
		DP_INV_NEXT,
		DP_RESULT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADDR,
		ST_PRB_RD,
		ST_PRB_CK,
		ST_FILL_RD,
		ST_FILL_CK,
		ST_ORD_RD,
		ST_ORD_CK,
		ST_UPD,
		ST_CALC,
		ST_ORD_WR,
		ST_FILL_WR,
		ST_INV_RD,
		ST_INV_CK,
		ST_INV_WR,
		ST_INV_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic mode_inv;
		logic prb_hit;
		logic prb_last;
		logic hit_found;
		logic ord_load_done;
		logic calc_any;
		logic calc_fill;
		logic ord_wr_last;
		logic fill_wr;
		logic inv_match;
		logic inv_last;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: design/saic_ctrl.sv
// Sequencer for lookups, page invalidates and the post-reset clearing pass.
module saic_ctrl
	import saic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_t after_lru;
		after_lru = stat.mode_inv ? ST_INV_NEXT : ST_DONE;
		state_d = state_q;
		cmd.op = DP_NOP;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLR: begin
				cmd.op = DP_CLR;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = DP_START;
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.op = DP_ADDR;
				state_d = stat.mode_inv ? ST_INV_RD : ST_PRB_RD;
			end
			ST_PRB_RD: begin
				cmd.op = DP_PRB_RD;
				state_d = ST_PRB_CK;
			end
			ST_PRB_CK: begin
				cmd.op = DP_PRB_CK;
				state_d = (stat.prb_hit || stat.prb_last) ? ST_FILL_RD : ST_PRB_RD;
			end
			ST_FILL_RD: begin
				cmd.op = DP_FILL_RD;
				state_d = ST_FILL_CK;
			end
			ST_FILL_CK: begin
				cmd.op = DP_FILL_CK;
				state_d = ST_ORD_RD;
			end
			ST_ORD_RD: begin
				if (stat.ord_load_done) begin
					state_d = stat.mode_inv ? ST_CALC : ST_UPD;
				end else begin
					cmd.op = DP_ORD_RD;
					state_d = ST_ORD_CK;
				end
			end
			ST_ORD_CK: begin
				cmd.op = DP_ORD_CK;
				state_d = ST_ORD_RD;
			end
			ST_UPD: begin
				cmd.op = stat.hit_found ? DP_HIT : DP_LINE_WR;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.op = DP_CALC;
				if (stat.calc_any) state_d = ST_ORD_WR;
				else if (stat.calc_fill) state_d = ST_FILL_WR;
				else state_d = after_lru;
			end
			ST_ORD_WR: begin
				cmd.op = DP_ORD_WR;
				if (stat.ord_wr_last) state_d = stat.fill_wr ? ST_FILL_WR : after_lru;
			end
			ST_FILL_WR: begin
				cmd.op = DP_FILL_WR;
				state_d = after_lru;
			end
			ST_INV_RD: begin
				cmd.op = DP_INV_RD;
				state_d = ST_INV_CK;
			end
			ST_INV_CK: begin
				state_d = stat.inv_match ? ST_INV_WR : ST_INV_NEXT;
			end
			ST_INV_WR: begin
				cmd.op = DP_INV_WR;
				state_d = ST_FILL_RD;
			end
			ST_INV_NEXT: begin
				cmd.op = DP_INV_NEXT;
				state_d = stat.inv_last ? ST_DONE : ST_INV_RD;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.op = DP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/saic_dpath.sv
// Tag, order and fill memories, address split, LRU update and counters.
module saic_dpath
	import saic_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [4:0]          cfg_data,
	input  logic                mode,
	input  logic [ADDR_BITS-1:0] pc,
	input  logic [PAGE_W-1:0]   page_number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [WAY_W-1:0]    way_used,
	output logic [31:0]         hit_count,
	output logic [31:0]         miss_count,
	output logic [CLR_W-1:0]    lines_cleared
);

	logic [3:0] bsl_q, scl_q, wc_q;
	logic [4:0] psl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q <= 4'd2;
			psl_q <= 5'd10;
			scl_q <= 4'd4;
			wc_q  <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_LOG2: bsl_q <= cfg_data[3:0];
				CFG_PAGE_LOG2:  psl_q <= cfg_data;
				CFG_SET_LOG2:   scl_q <= cfg_data[3:0];
				CFG_WAY_COUNT:  wc_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [3:0] eff_w, eff_sl;
	always_comb begin
		if (wc_q == 4'd0) eff_w = 4'd1;
		else if (wc_q > 4'd8) eff_w = 4'd8;
		else eff_w = wc_q;
		eff_sl = 4'd0;
		for (int l = 0; l < 16; l++) begin
			if (4'(l) <= scl_q && ({16'd0, eff_w} << l) <= 20'(LINE_COUNT)) eff_sl = 4'(l);
		end
	end

	logic                 mode_q;
	logic [ADDR_BITS-1:0] pc_q;
	logic [PAGE_W-1:0]    page_q;

	logic [63:0]          off_c, pa_full_c;
	logic [ADDR_BITS-1:0] blk_c, tag_c;
	logic [LINE_AW-1:0]   set_c, base_c;
	logic [13:0]          base_prod_c;

	always_comb begin
		off_c = {32'd0, pc_q} & ((64'd1 << psl_q) - 64'd1);
		pa_full_c = ({44'd0, page_q} << psl_q) | off_c;
		blk_c = pa_full_c[ADDR_BITS-1:0] >> bsl_q;
		set_c = LINE_AW'(blk_c & ((32'd1 << eff_sl) - 32'd1));
		tag_c = blk_c >> eff_sl;
		base_prod_c = set_c * eff_w;
		base_c = base_prod_c[LINE_AW-1:0];
	end

	logic [LINE_AW-1:0] set_q, base_q, inv_i_q, iset_q, clr_i_q;
	logic [TAG_W-1:0]   tag_q;
	logic [WAY_W-1:0]   way_q, pw_q, free_way_q, iway_q;
	logic               found_q, free_found_q, fill_wr_q;
	logic [FILL_W-1:0]  f_q, pos_q, hi_q, nf_q;
	logic [WAY_W-1:0]   arr_q [MAX_WAYS];
	logic [WAY_W-1:0]   new_q [MAX_WAYS];
	logic [CLR_W-1:0]   cleared_q;
	logic [31:0]        hit_cnt_q, miss_cnt_q;

	logic [LINE_DW-1:0] line_mem [LINE_COUNT];
	logic [WAY_W-1:0]   ord_mem  [LINE_COUNT];
	logic [FILL_W-1:0]  fill_mem [LINE_COUNT];
	logic [LINE_DW-1:0] line_rd_q;
	logic [WAY_W-1:0]   ord_rd_q;
	logic [FILL_W-1:0]  fill_rd_q;

	// line word: valid, tag, page
	logic              rd_valid, rd_tag_eq, rd_page_eq;
	assign rd_valid   = line_rd_q[LINE_DW-1];
	assign rd_tag_eq  = (line_rd_q[LINE_DW-2:PAGE_W] == tag_q);
	assign rd_page_eq = (line_rd_q[PAGE_W-1:0] == page_q);

	logic [WAY_W-1:0] victim_c;
	always_comb begin
		if (free_found_q) victim_c = free_way_q;
		else if (f_q != 4'd0 && {1'b0, arr_q[0]} < eff_w) victim_c = arr_q[0];
		else victim_c = '0;
	end

	// LRU touch / remove on the loaded order of one set
	logic             c_found, c_any, c_fill;
	logic [WAY_W-1:0] c_p, c_ps;
	logic [FILL_W-1:0] c_lo, c_hi, c_nf, f_m1;
	logic [WAY_W-1:0] c_new [MAX_WAYS];
	always_comb begin
		c_found = 1'b0;
		c_p = '0;
		f_m1 = f_q - 4'd1;
		for (int p = 0; p < MAX_WAYS; p++) begin
			if (!c_found && 4'(p) < f_q && arr_q[p] == way_q) begin
				c_found = 1'b1;
				c_p = WAY_W'(p);
			end
		end
		c_new = arr_q;
		c_lo = '0;
		c_hi = '0;
		c_any = 1'b0;
		c_fill = 1'b0;
		c_nf = f_q;
		c_ps = c_found ? c_p : '0;
		if (!mode_q) begin
			if (!c_found && f_q < eff_w) begin
				c_new[f_q[WAY_W-1:0]] = way_q;
				c_lo = f_q;
				c_hi = f_q;
				c_any = 1'b1;
				c_fill = 1'b1;
				c_nf = f_q + 4'd1;
			end else begin
				for (int q = 0; q < MAX_WAYS - 1; q++) begin
					if (4'(q) >= {1'b0, c_ps} && 4'(q) + 4'd1 < f_q) c_new[q] = arr_q[q + 1];
				end
				c_new[f_m1[WAY_W-1:0]] = way_q;
				c_lo = {1'b0, c_ps};
				c_hi = f_m1;
				c_any = 1'b1;
				c_fill = 1'b1;
				c_nf = f_q;
			end
		end else if (c_found) begin
			for (int q = 0; q < MAX_WAYS - 1; q++) begin
				if (4'(q) >= {1'b0, c_p} && 4'(q) + 4'd1 < f_q) c_new[q] = arr_q[q + 1];
			end
			c_lo = {1'b0, c_p};
			c_hi = f_q - 4'd2;
			c_any = ({1'b0, c_p} + 4'd1 < f_q);
			c_fill = 1'b1;
			c_nf = f_m1;
		end
	end

	// memory ports
	logic               line_re, line_we, ord_re, ord_we, fill_re, fill_we;
	logic [LINE_AW-1:0] line_ra, line_wa, ord_a, fill_a;
	logic [LINE_DW-1:0] line_wd;
	logic [FILL_W-1:0]  fill_wd;

	always_comb begin
		line_re = (cmd.op == DP_PRB_RD) || (cmd.op == DP_INV_RD);
		line_ra = (cmd.op == DP_INV_RD) ? inv_i_q : base_q + LINE_AW'(pw_q);
		line_we = 1'b0;
		line_wa = clr_i_q;
		line_wd = '0;
		case (cmd.op)
			DP_CLR: line_we = 1'b1;
			DP_LINE_WR: begin
				line_we = 1'b1;
				line_wa = base_q + LINE_AW'(victim_c);
				line_wd = {1'b1, tag_q, page_q};
			end
			DP_INV_WR: begin
				line_we = 1'b1;
				line_wa = inv_i_q;
				line_wd = {1'b0, line_rd_q[LINE_DW-2:0]};
			end
			default: ;
		endcase
		ord_re = (cmd.op == DP_ORD_RD);
		ord_we = (cmd.op == DP_ORD_WR);
		ord_a = base_q + LINE_AW'(pos_q);
		fill_re = (cmd.op == DP_FILL_RD);
		fill_we = (cmd.op == DP_CLR) || (cmd.op == DP_FILL_WR);
		fill_a = (cmd.op == DP_CLR) ? clr_i_q : set_q;
		fill_wd = (cmd.op == DP_CLR) ? '0 : nf_q;
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_wa] <= line_wd;
		if (line_re) line_rd_q <= line_mem[line_ra];
		if (ord_we) ord_mem[ord_a] <= new_q[pos_q[WAY_W-1:0]];
		if (ord_re) ord_rd_q <= ord_mem[ord_a];
		if (fill_we) fill_mem[fill_a] <= fill_wd;
		if (fill_re) fill_rd_q <= fill_mem[fill_a];
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START: begin
				mode_q <= mode;
				pc_q <= pc;
				page_q <= page_number;
			end
			DP_ADDR: begin
				set_q <= set_c;
				tag_q <= tag_c;
				base_q <= base_c;
				pw_q <= '0;
				inv_i_q <= '0;
				iway_q <= '0;
				iset_q <= '0;
			end
			DP_PRB_CK: begin
				pw_q <= pw_q + 3'd1;
				if (rd_valid && rd_tag_eq) way_q <= pw_q;
				if (!rd_valid && !free_found_q) free_way_q <= pw_q;
			end
			DP_FILL_CK: begin
				f_q <= (fill_rd_q > eff_w) ? eff_w : fill_rd_q;
				pos_q <= '0;
			end
			DP_ORD_CK: begin
				arr_q[pos_q[WAY_W-1:0]] <= ord_rd_q;
				pos_q <= pos_q + 4'd1;
			end
			DP_LINE_WR: way_q <= victim_c;
			DP_CALC: begin
				new_q <= c_new;
				pos_q <= c_lo;
				hi_q <= c_hi;
				nf_q <= c_nf;
				fill_wr_q <= c_fill;
			end
			DP_ORD_WR: pos_q <= pos_q + 4'd1;
			DP_INV_WR: begin
				set_q <= iset_q;
				base_q <= inv_i_q - LINE_AW'(iway_q);
				way_q <= iway_q;
			end
			DP_INV_NEXT: begin
				inv_i_q <= inv_i_q + 10'd1;
				if ({1'b0, iway_q} == eff_w - 4'd1) begin
					iway_q <= '0;
					iset_q <= iset_q + 10'd1;
				end else begin
					iway_q <= iway_q + 3'd1;
				end
			end
			default: ;
		endcase
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_i_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			cleared_q <= '0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == DP_CLR) clr_i_q <= clr_i_q + 10'd1;
			if (cmd.op == DP_START) cleared_q <= '0;
			if (cmd.op == DP_ADDR) begin
				found_q <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmd.op == DP_PRB_CK) begin
				if (rd_valid && rd_tag_eq) found_q <= 1'b1;
				if (!rd_valid) free_found_q <= 1'b1;
			end
			if (cmd.op == DP_HIT && hit_cnt_q != 32'hFFFF_FFFF) hit_cnt_q <= hit_cnt_q + 32'd1;
			if (cmd.op == DP_LINE_WR && miss_cnt_q != 32'hFFFF_FFFF)
				miss_cnt_q <= miss_cnt_q + 32'd1;
			if (cmd.op == DP_INV_WR && cleared_q != 11'h7FF) cleared_q <= cleared_q + 11'd1;
			if (cmd.op == DP_RESULT) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_RESULT) begin
			hit <= !mode_q && found_q;
			way_used <= mode_q ? '0 : way_q;
			hit_count <= hit_cnt_q;
			miss_count <= miss_cnt_q;
			lines_cleared <= cleared_q;
		end
	end

	always_comb begin
		stat.mode_inv      = mode_q;
		stat.prb_hit       = rd_valid && rd_tag_eq;
		stat.prb_last      = ({1'b0, pw_q} == eff_w - 4'd1);
		stat.hit_found     = found_q;
		stat.ord_load_done = (pos_q == f_q);
		stat.calc_any      = c_any;
		stat.calc_fill     = c_fill;
		stat.ord_wr_last   = (pos_q == hi_q);
		stat.fill_wr       = fill_wr_q;
		stat.inv_match     = rd_valid && rd_page_eq;
		stat.inv_last      = (inv_i_q == 10'(LINE_COUNT - 1));
		stat.clr_last      = (clr_i_q == 10'(LINE_COUNT - 1));
		stat.out_free      = !out_valid || !out_stall;
	end

`ifndef SYNTHESIS
	a_ord_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_ORD_RD |-> pos_q < f_q) else $error("order read past fill");
	a_ord_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_ORD_WR |-> pos_q <= hi_q) else $error("order write past range");
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_LINE_WR |-> !found_q) else $error("line fill on a hit");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_FILL_WR |-> nf_q <= eff_w) else $error("fill count above ways");
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_RESULT |=> out_valid) else $error("result not presented");
`endif

endmodule

FILE: design/set_assoc_icache_lru_top.sv
// Top level of the instruction-cache tag block with LRU replacement.
// Input channel (in_valid/in_stall): one transaction is a lookup (mode 0,
// pc, page_number) or a page invalidate (mode 1, page_number).
// Output channel (out_valid/out_stall): exactly one result per input:
// hit, way_used, saturating hit/miss totals and lines_cleared.
// Config channel (cfg_valid/cfg_ready): register index and data; always
// ready; write only while the block is idle.
// A lookup probes the set's ways until a tag hit or the last way, loads
// the set's LRU order, then rewrites the changed order entries and the
// fill count.
// Invalidate walks all 1024 lines; each valid line of the page is cleared
// and removed from its set's LRU order.
// One item is processed at a time; the next is taken once the
// previous one has reached the output register, even if it is still stalled.
// A finished result waits in the sequencer while out_stall holds the
// previous one; payload on the output stays stable while stalled.
// After reset a clearing pass over all 1024 lines zeroes valid bits and fill counts;
// in_stall is high during it.
module set_assoc_icache_lru_top
	import saic_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [ADDR_BITS-1:0] pc,
	input  logic [PAGE_W-1:0]    page_number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic [WAY_W-1:0]     way_used,
	output logic [31:0]          hit_count,
	output logic [31:0]          miss_count,
	output logic [CLR_W-1:0]     lines_cleared,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [4:0]           cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	saic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	saic_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.pc            (pc),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.way_used      (way_used),
		.hit_count     (hit_count),
		.miss_count    (miss_count),
		.lines_cleared (lines_cleared)
	);

endmodule
